/* rtl/core/sbd_pkg.sv */
package sbd_pkg;

   // Field widths
   localparam int DEPTH_CM_W = 15;
   localparam int HYST_W     = 10;
   localparam int LIMIT_W    = 10;
   localparam int TRIG_W     = 16;
   localparam int VEL_W      = 15;
   localparam int DEPTH_W    = 18;

   // Threshold math: cm * 10 minus hysteresis fits in 21 bits signed
   localparam int THR_W = 21;
   // Velocity compare width: covers +/- the 10-bit limit and 15-bit velocity
   localparam int CMP_VEL_W = 16;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   // APB register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_SURFACE_DEPTH = 3'd0,
      REG_SURFACE_HYST  = 3'd1,
      REG_STATION_LIMIT = 3'd2,
      REG_SURFACE_TRIG  = 3'd3,
      REG_BOTTOM_TRIG   = 3'd4
   } csr_index_type;

   localparam logic signed [DEPTH_CM_W-1:0] SURFACE_DEPTH_RESET = -15'sd10;
   localparam logic [HYST_W-1:0]            SURFACE_HYST_RESET  = 10'd50;
   localparam logic [LIMIT_W-1:0]           STATION_LIMIT_RESET = 10'd50;
   localparam logic [TRIG_W-1:0]            SURFACE_TRIG_RESET  = 16'd400;
   localparam logic [TRIG_W-1:0]            BOTTOM_TRIG_RESET   = 16'd400;

endpackage

/* rtl/core/sbd_if.sv */
interface sbd_req_if;
   import sbd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       armed;
   logic                       sensor_present;
   logic signed [VEL_W-1:0]    vertical_velocity_mm_s;
   logic signed [DEPTH_W-1:0]  depth_mm;
   logic                       throttle_at_lower;
   logic                       throttle_at_upper;

   modport source (
      output valid, armed, sensor_present, vertical_velocity_mm_s,
             depth_mm, throttle_at_lower, throttle_at_upper,
      input  ready
   );

   modport sink (
      input  valid, armed, sensor_present, vertical_velocity_mm_s,
             depth_mm, throttle_at_lower, throttle_at_upper,
      output ready
   );
endinterface

interface sbd_rsp_if;
   logic valid;
   logic ready;
   logic surfaced;
   logic bottomed;
   logic surface_changed;
   logic bottom_changed;

   modport source (
      output valid, surfaced, bottomed, surface_changed, bottom_changed,
      input  ready
   );

   modport sink (
      input  valid, surfaced, bottomed, surface_changed, bottom_changed,
      output ready
   );
endinterface

/* rtl/core/surface_bottom_detector.sv */
// Surface / bottom detector. Each request beat is one control-loop tick
// (armed, depth sensor present, vertical velocity, depth, throttle limit
// flags); each tick yields exactly one response beat with the surfaced and
// bottomed flags after the tick and a changed bit for each. A beat is
// registered on entry, evaluated combinationally against the flag/counter
// state with compares and counter updates, and lands in the response
// register, so the block sustains one beat per clock while rsp_bus.ready
// stays high; the response register lets a new beat enter while the previous
// result waits for rsp_bus.ready. Thresholds, hysteresis, stationary limit
// and trigger tick counts come from the APB registers (byte address 4*i),
// which should only be written while no beat is in flight.
module surface_bottom_detector #(
   parameter int COUNT_WIDTH = sbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   sbd_req_if.sink                           req_bus,
   sbd_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sbd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sbd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sbd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sbd_pkg::*;

   // Counter compare width: wide enough for both counter and trigger
   localparam int CNT_CMP_W = (COUNT_WIDTH > TRIG_W) ? COUNT_WIDTH : TRIG_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [DEPTH_CM_W-1:0] surface_depth_ff;
   logic [HYST_W-1:0]            surface_hyst_ff;
   logic [LIMIT_W-1:0]           station_limit_ff;
   logic [TRIG_W-1:0]            surface_trig_ff;
   logic [TRIG_W-1:0]            bottom_trig_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_depth_ff <= SURFACE_DEPTH_RESET;
         surface_hyst_ff  <= SURFACE_HYST_RESET;
         station_limit_ff <= STATION_LIMIT_RESET;
         surface_trig_ff  <= SURFACE_TRIG_RESET;
         bottom_trig_ff   <= BOTTOM_TRIG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SURFACE_DEPTH: surface_depth_ff <= signed'(csr_pwdata[DEPTH_CM_W-1:0]);
            REG_SURFACE_HYST:  surface_hyst_ff  <= csr_pwdata[HYST_W-1:0];
            REG_STATION_LIMIT: station_limit_ff <= csr_pwdata[LIMIT_W-1:0];
            REG_SURFACE_TRIG:  surface_trig_ff  <= csr_pwdata[TRIG_W-1:0];
            REG_BOTTOM_TRIG:   bottom_trig_ff   <= csr_pwdata[TRIG_W-1:0];
            default: ;  // unmapped, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SURFACE_DEPTH: csr_prdata = CSR_DATA_W'(unsigned'(surface_depth_ff));
         REG_SURFACE_HYST:  csr_prdata = CSR_DATA_W'(surface_hyst_ff);
         REG_STATION_LIMIT: csr_prdata = CSR_DATA_W'(station_limit_ff);
         REG_SURFACE_TRIG:  csr_prdata = CSR_DATA_W'(surface_trig_ff);
         REG_BOTTOM_TRIG:   csr_prdata = CSR_DATA_W'(bottom_trig_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic                      in_valid_ff;
   logic                      armed_ff;
   logic                      sensor_ff;
   logic signed [VEL_W-1:0]   vel_ff;
   logic signed [DEPTH_W-1:0] depth_ff;
   logic                      lower_ff;
   logic                      upper_ff;

   logic rsp_valid_ff;
   logic advance;   // beat moves from input reg to response reg
   logic req_fire;

   assign advance       = in_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_fire      = req_bus.valid & req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         armed_ff  <= req_bus.armed;
         sensor_ff <= req_bus.sensor_present;
         vel_ff    <= req_bus.vertical_velocity_mm_s;
         depth_ff  <= req_bus.depth_mm;
         lower_ff  <= req_bus.throttle_at_lower;
         upper_ff  <= req_bus.throttle_at_upper;
      end
   end

   // ---------------------------------------------------------------
   // Tick evaluation
   // ---------------------------------------------------------------
   logic                   surface_flag_ff, surface_flag_in;
   logic                   bottom_flag_ff,  bottom_flag_in;
   logic [COUNT_WIDTH-1:0] surface_count_ff, surface_count_in;
   logic [COUNT_WIDTH-1:0] bottom_count_ff,  bottom_count_in;

   logic signed [THR_W-1:0]     depth_cm_ext;
   logic signed [THR_W-1:0]     thr;        // threshold in mm
   logic signed [THR_W-1:0]     thr_hyst;   // threshold minus hysteresis
   logic signed [THR_W-1:0]     depth_ext;
   logic signed [CMP_VEL_W-1:0] lim;
   logic signed [CMP_VEL_W-1:0] vel_ext;
   logic                        still;
   logic                        above_thr;
   logic                        above_hyst;
   logic                        surface_due;   // counter reached trigger
   logic                        bottom_due;
   logic [COUNT_WIDTH-1:0]      surface_count_inc;
   logic [COUNT_WIDTH-1:0]      bottom_count_inc;

   always_comb begin
      depth_cm_ext = THR_W'(surface_depth_ff);
      thr          = (depth_cm_ext <<< 3) + (depth_cm_ext <<< 1);
      thr_hyst     = thr - signed'(THR_W'(surface_hyst_ff));
      depth_ext    = THR_W'(depth_ff);
      above_thr    = depth_ext > thr;
      above_hyst   = depth_ext > thr_hyst;

      lim     = signed'(CMP_VEL_W'(station_limit_ff));
      vel_ext = CMP_VEL_W'(vel_ff);
      still   = (vel_ext > -lim) && (vel_ext < lim);

      surface_due = CNT_CMP_W'(surface_count_ff) >= CNT_CMP_W'(surface_trig_ff);
      bottom_due  = CNT_CMP_W'(bottom_count_ff)  >= CNT_CMP_W'(bottom_trig_ff);
      // saturate at the top of the counter
      surface_count_inc = (surface_count_ff == COUNT_MAX) ? surface_count_ff
                                                          : surface_count_ff + 1'b1;
      bottom_count_inc  = (bottom_count_ff == COUNT_MAX) ? bottom_count_ff
                                                         : bottom_count_ff + 1'b1;
   end

   always_comb begin
      surface_flag_in  = surface_flag_ff;
      bottom_flag_in   = bottom_flag_ff;
      surface_count_in = surface_count_ff;
      bottom_count_in  = bottom_count_ff;

      if (!armed_ff) begin
         // disarmed: flags drop, counters hold
         surface_flag_in = 1'b0;
         bottom_flag_in  = 1'b0;
      end else if (sensor_ff) begin
         // depth-based surfacing
         if (surface_flag_ff) begin
            surface_flag_in = above_hyst;
         end else if (above_thr) begin
            if (surface_due) begin
               surface_flag_in  = 1'b1;
               surface_count_in = '0;
            end else begin
               surface_count_in = surface_count_inc;
            end
         end else begin
            surface_count_in = '0;
            surface_flag_in  = 1'b0;
         end
         // bottoming: lower limit while stationary
         if (lower_ff && still) begin
            if (bottom_due) begin
               if (!bottom_flag_ff) begin
                  bottom_count_in = '0;
               end
               bottom_flag_in = 1'b1;
            end else begin
               bottom_count_in = bottom_count_inc;
            end
         end else begin
            bottom_count_in = '0;
            bottom_flag_in  = 1'b0;
         end
      end else if (still) begin
         // no sensor: upper limit wins over lower
         if (upper_ff) begin
            if (surface_due) begin
               if (!surface_flag_ff) begin
                  surface_count_in = '0;
               end
               surface_flag_in = 1'b1;
            end else begin
               surface_count_in = surface_count_inc;
            end
         end else if (lower_ff) begin
            if (bottom_due) begin
               if (!bottom_flag_ff) begin
                  bottom_count_in = '0;
               end
               bottom_flag_in = 1'b1;
            end else begin
               bottom_count_in = bottom_count_inc;
            end
         end else begin
            surface_flag_in = 1'b0;
            bottom_flag_in  = 1'b0;
         end
      end else begin
         surface_flag_in = 1'b0;
         bottom_flag_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_flag_ff  <= 1'b0;
         bottom_flag_ff   <= 1'b0;
         surface_count_ff <= '0;
         bottom_count_ff  <= '0;
      end else if (advance) begin
         surface_flag_ff  <= surface_flag_in;
         bottom_flag_ff   <= bottom_flag_in;
         surface_count_ff <= surface_count_in;
         bottom_count_ff  <= bottom_count_in;
      end
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic surfaced_ff;
   logic bottomed_ff;
   logic surface_changed_ff;
   logic bottom_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         surfaced_ff        <= surface_flag_in;
         bottomed_ff        <= bottom_flag_in;
         surface_changed_ff <= surface_flag_in ^ surface_flag_ff;
         bottom_changed_ff  <= bottom_flag_in ^ bottom_flag_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.surfaced        = surfaced_ff;
   assign rsp_bus.bottomed        = bottomed_ff;
   assign rsp_bus.surface_changed = surface_changed_ff;
   assign rsp_bus.bottom_changed  = bottom_changed_ff;

endmodule

/* dv/surface_bottom_detector_test.sv */
module surface_bottom_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sbd_pkg::*;

   // Only the default counter width is built here.
   localparam int COUNT_W    = COUNT_WIDTH_DEFAULT;
   localparam int NUM_REGS   = 5;
   // Drain margin once no response is outstanding.
   localparam int DRAIN_WAIT = 6;

   // One control-loop tick as it goes into the block.
   typedef struct {
      logic                      armed;
      logic                      sensor;
      logic signed [VEL_W-1:0]   vel;
      logic signed [DEPTH_W-1:0] depth;
      logic                      lower;
      logic                      upper;
   } tick_type;

   // Flags that come back for one tick.
   typedef struct packed {
      logic surfaced;
      logic bottomed;
      logic surface_changed;
      logic bottom_changed;
   } flags_type;

   // Shapes of random bursts: each holds one kind of situation for a while.
   typedef enum int {
      DIVE_UP,
      SIT_BOTTOM,
      HOVER_EDGE,
      NO_SENSOR,
      NOISE
   } burst_kind_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sbd_req_if req_bus();
   sbd_rsp_if rsp_bus();

   surface_bottom_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Detector state as this bench tracks it
   // ------------------------------------------------------------------
   logic [31:0]        csr_shadow [NUM_REGS];
   logic               surf_flag;
   logic               bot_flag;
   logic [COUNT_W-1:0] surf_cnt;
   logic [COUNT_W-1:0] bot_cnt;

   flags_type queued_flags [$];

   int  failures;
   int  ticks_sent;
   int  beats_checked;
   int  surface_rises;
   int  bottom_rises;
   int  settings_used;
   // When set, neither side inserts gaps: back-to-back beats.
   bit  steady_flow;

   function automatic logic [31:0] reg_mask(csr_index_type idx);
      int w;
      case (idx)
         REG_SURFACE_DEPTH: w = DEPTH_CM_W;
         REG_SURFACE_HYST:  w = HYST_W;
         REG_STATION_LIMIT: w = LIMIT_W;
         REG_SURFACE_TRIG:  w = TRIG_W;
         REG_BOTTOM_TRIG:   w = TRIG_W;
         default:           w = 0;
      endcase
      return 32'((64'd1 << w) - 64'd1);
   endfunction

   function automatic int surface_threshold_mm();
      logic signed [DEPTH_CM_W-1:0] cm;
      cm = csr_shadow[REG_SURFACE_DEPTH][DEPTH_CM_W-1:0];
      return cm * 10;
   endfunction

   function automatic logic [COUNT_W-1:0] bump_count(logic [COUNT_W-1:0] cnt);
      return (cnt == {COUNT_W{1'b1}}) ? cnt : cnt + 1'b1;
   endfunction

   // A flag going true restarts its counter.
   function automatic void set_surface(logic v);
      if (v && !surf_flag) surf_cnt = '0;
      surf_flag = v;
   endfunction

   function automatic void set_bottom(logic v);
      if (v && !bot_flag) bot_cnt = '0;
      bot_flag = v;
   endfunction

   // Counter below trigger counts up; at trigger the flag sets.
   function automatic void qualify_surface();
      if (surf_cnt >= csr_shadow[REG_SURFACE_TRIG][TRIG_W-1:0]) set_surface(1'b1);
      else surf_cnt = bump_count(surf_cnt);
   endfunction

   function automatic void qualify_bottom();
      if (bot_cnt >= csr_shadow[REG_BOTTOM_TRIG][TRIG_W-1:0]) set_bottom(1'b1);
      else bot_cnt = bump_count(bot_cnt);
   endfunction

   // Advance the tracked state by one tick and return the flags it yields.
   function automatic flags_type step_detector(tick_type t);
      flags_type f;
      logic      s0, b0, still;
      int        vel, dep, lim, thr, hyst;
      s0    = surf_flag;
      b0    = bot_flag;
      vel   = t.vel;
      dep   = t.depth;
      lim   = int'(csr_shadow[REG_STATION_LIMIT][LIMIT_W-1:0]);
      hyst  = int'(csr_shadow[REG_SURFACE_HYST][HYST_W-1:0]);
      thr   = surface_threshold_mm();
      still = (vel > -lim) && (vel < lim);

      if (!t.armed) begin
         set_surface(1'b0);
         set_bottom(1'b0);
      end else if (t.sensor) begin
         // once surfaced the counter is left alone; hysteresis decides
         if (surf_flag) begin
            set_surface(dep > thr - hyst);
         end else if (dep > thr) begin
            qualify_surface();
         end else begin
            surf_cnt = '0;
            set_surface(1'b0);
         end
         if (t.lower && still) begin
            qualify_bottom();
         end else begin
            bot_cnt = '0;
            set_bottom(1'b0);
         end
      end else if (still) begin
         // no sensor: upper limit wins over lower, the other side holds
         if (t.upper) begin
            qualify_surface();
         end else if (t.lower) begin
            qualify_bottom();
         end else begin
            set_surface(1'b0);
            set_bottom(1'b0);
         end
      end else begin
         set_surface(1'b0);
         set_bottom(1'b0);
      end

      f.surfaced        = surf_flag;
      f.bottomed        = bot_flag;
      f.surface_changed = surf_flag != s0;
      f.bottom_changed  = bot_flag != b0;
      return f;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      return steady_flow ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic tick_type make_tick(int armed, int sensor, int vel, int depth,
                                          int lower, int upper);
      tick_type t;
      t.armed  = armed[0];
      t.sensor = sensor[0];
      t.vel    = VEL_W'(vel);
      t.depth  = DEPTH_W'(depth);
      t.lower  = lower[0];
      t.upper  = upper[0];
      return t;
   endfunction

   // Inside the stationary band, around its edges, or anywhere in the field.
   function automatic logic signed [VEL_W-1:0] pick_velocity(bit still_side);
      int          lim;
      logic [31:0] bits;
      lim  = int'(csr_shadow[REG_STATION_LIMIT][LIMIT_W-1:0]);
      bits = $urandom();
      if (still_side && lim > 0)
         return VEL_W'(int'($urandom_range(0, 2 * lim - 2)) - (lim - 1));
      if (bits[31]) return VEL_W'(int'($urandom_range(0, 2 * lim + 4)) - lim - 2);
      return bits[VEL_W-1:0];
   endfunction

   // 0: across the hysteresis band, 1: above threshold, else any value.
   function automatic logic signed [DEPTH_W-1:0] pick_depth(int mode);
      int          thr, hyst;
      logic [31:0] bits;
      thr  = surface_threshold_mm();
      hyst = int'(csr_shadow[REG_SURFACE_HYST][HYST_W-1:0]);
      bits = $urandom();
      case (mode)
         0:       return DEPTH_W'(thr - hyst - 4 + int'($urandom_range(0, hyst + 8)));
         1:       return DEPTH_W'(thr + 1 + int'($urandom_range(0, 3000)));
         default: return bits[DEPTH_W-1:0];
      endcase
   endfunction

   function automatic tick_type draw_tick(burst_kind_type kind, logic sensor);
      tick_type    t;
      logic [31:0] bits;
      bits     = $urandom();
      // occasional disarm blip inside an otherwise clean burst
      t.armed  = ($urandom_range(0, 19) != 0);
      t.sensor = sensor;
      t.lower  = bits[0];
      t.upper  = bits[1];
      t.vel    = pick_velocity(bits[2] | bits[3]);
      t.depth  = pick_depth(bits[4] ? 0 : 1);
      case (kind)
         DIVE_UP: begin
            t.sensor = 1'b1;
            t.depth  = pick_depth(bits[5] & bits[6] ? 0 : 1);
         end
         SIT_BOTTOM: begin
            t.lower = 1'b1;
            t.upper = sensor ? bits[1] : 1'b0;
         end
         HOVER_EDGE: begin
            t.sensor = 1'b1;
            t.depth  = pick_depth(0);
            t.vel    = pick_velocity(1'b0);
         end
         NO_SENSOR: t.sensor = 1'b0;
         default: begin
            t.armed  = bits[7];
            t.sensor = bits[8];
            t.vel    = pick_velocity(1'b0);
            t.depth  = pick_depth(2);
         end
      endcase
      return t;
   endfunction

   // ------------------------------------------------------------------
   // Bus tasks
   // ------------------------------------------------------------------
   // Drive one tick; the flags it should produce are queued on acceptance.
   task automatic send_tick(tick_type t);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid                  <= 1'b1;
      req_bus.armed                  <= t.armed;
      req_bus.sensor_present         <= t.sensor;
      req_bus.vertical_velocity_mm_s <= t.vel;
      req_bus.depth_mm               <= t.depth;
      req_bus.throttle_at_lower      <= t.lower;
      req_bus.throttle_at_upper      <= t.upper;
      do @(posedge clock); while (!req_bus.ready);
      queued_flags.push_back(step_detector(t));
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (queued_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // psel stays up between transfers; csr_release drops it after a batch.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx < NUM_REGS) csr_shadow[idx] = value & reg_mask(csr_index_type'(idx));
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(csr_index_type idx);
      logic [31:0] got;
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr  <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata & reg_mask(idx);
      if (got !== csr_shadow[idx]) begin
         failures++;
         $display("%0t csr readback %s: expected %0h got %0h",
                  $time, idx.name(), csr_shadow[idx], got);
      end
      csr_penable <= 1'b0;
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
   endtask

   task automatic read_back_all();
      csr_index_type idx;
      idx = idx.first();
      repeat (NUM_REGS) begin
         csr_read_check(idx);
         idx = idx.next();
      end
   endtask

   // New settings, only once the pipe is empty.
   task automatic configure(int depth_cm, int hyst, int lim, int strig, int btrig);
      wait_drained();
      csr_write(REG_SURFACE_DEPTH, 32'(depth_cm));
      csr_write(REG_SURFACE_HYST,  32'(hyst));
      csr_write(REG_STATION_LIMIT, 32'(lim));
      csr_write(REG_SURFACE_TRIG,  32'(strig));
      csr_write(REG_BOTTOM_TRIG,   32'(btrig));
      read_back_all();
      csr_release();
      settings_used++;
   endtask

   task automatic run_bursts(int count);
      int             sent, len;
      burst_kind_type kind;
      logic           sensor;
      sent = 0;
      while (sent < count) begin
         kind        = burst_kind_type'($urandom_range(0, 4));
         sensor      = 1'($urandom_range(0, 1));
         len         = $urandom_range(1, 24);
         if (len > count - sent) len = count - sent;
         steady_flow = ($urandom_range(0, 4) == 0);
         repeat (len) begin
            send_tick(draw_tick(kind, sensor));
            sent++;
         end
      end
      steady_flow = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset values, a write to an unmapped address, then full-width writes.
   task automatic test_register_access();
      logic [2:0] spare;
      read_back_all();
      spare = 3'(NUM_REGS + $urandom_range(0, 7 - NUM_REGS));
      csr_write(spare, $urandom());
      read_back_all();
      csr_write(REG_SURFACE_DEPTH, $urandom());
      csr_write(REG_SURFACE_HYST,  $urandom());
      csr_write(REG_STATION_LIMIT, $urandom());
      csr_write(REG_SURFACE_TRIG,  $urandom());
      csr_write(REG_BOTTOM_TRIG,   $urandom());
      read_back_all();
      csr_release();
   endtask

   // Threshold -100 mm, band 50, stationary below 50, qualify after 2 ticks.
   task automatic test_directed_cases();
      configure(-10, 50, 50, 2, 2);
      // disarmed with everything else high
      send_tick(make_tick(0, 1, 16383, 131071, 1, 1));
      // depth equal to threshold does not count
      send_tick(make_tick(1, 1, 0, -100, 0, 0));
      repeat (3) send_tick(make_tick(1, 1, 0, -99, 0, 0));
      // hysteresis holds just inside the band, drops at its edge
      send_tick(make_tick(1, 1, 0, -149, 0, 0));
      send_tick(make_tick(1, 1, 0, -150, 0, 0));
      // stationary band edges on the bottom side
      repeat (3) send_tick(make_tick(1, 1, 49, -5000, 1, 0));
      send_tick(make_tick(1, 1, 50, -5000, 1, 0));
      send_tick(make_tick(1, 1, -49, -5000, 1, 0));
      send_tick(make_tick(1, 1, -50, -5000, 1, 0));
      // no sensor: both limits, upper wins
      repeat (3) send_tick(make_tick(1, 0, 0, 0, 1, 1));
      // lower only: bottom qualifies, surface holds
      repeat (3) send_tick(make_tick(1, 0, -10, -131072, 1, 0));
      send_tick(make_tick(1, 0, 0, 0, 0, 0));
      send_tick(make_tick(1, 0, -16384, 0, 1, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 0));
      // field extremes with a sensor
      send_tick(make_tick(1, 1, 16383, 131071, 0, 1));
      send_tick(make_tick(1, 1, -16384, -131072, 1, 1));
   endtask

   // Register extremes: instant qualification, never-reached triggers,
   // zero and 1000 mm hysteresis, empty and wide stationary bands.
   task automatic test_extreme_settings();
      configure(-10000, 1000, 1000, 0, 0);
      run_bursts(80);
      configure(0, 0, 0, 65535, 65535);
      run_bursts(80);
      configure(0, 1000, 1, 1, 65535);
      run_bursts(80);
   endtask

   task automatic test_random_traffic();
      repeat (6) begin
         configure(-int'($urandom_range(0, 10000)), $urandom_range(0, 1000),
                   $urandom_range(0, 1000), $urandom_range(0, 12),
                   $urandom_range(0, 12));
         run_bursts(215);
      end
   endtask

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic report_field(string name, logic want, logic got);
      if (want !== got) begin
         failures++;
         $display("%0t %s: expected %0b got %0b", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      flags_type got;
      flags_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.surfaced, rsp_bus.bottomed,
                rsp_bus.surface_changed, rsp_bus.bottom_changed};
         if (queued_flags.size() == 0) begin
            failures++;
            $display("%0t response beat with no tick outstanding: expected none got %b",
                     $time, got);
         end else begin
            want = queued_flags.pop_front();
            report_field("surfaced",        want.surfaced,        got.surfaced);
            report_field("bottomed",        want.bottomed,        got.bottomed);
            report_field("surface_changed", want.surface_changed, got.surface_changed);
            report_field("bottom_changed",  want.bottom_changed,  got.bottom_changed);
            beats_checked++;
            if (want.surfaced && want.surface_changed) surface_rises++;
            if (want.bottomed && want.bottom_changed) bottom_rises++;
         end
      end
   end

   // Response side drops ready for a random stall before taking each beat.
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset                          <= 1'b1;
      req_bus.valid                  <= 1'b0;
      req_bus.armed                  <= 1'b0;
      req_bus.sensor_present         <= 1'b0;
      req_bus.vertical_velocity_mm_s <= '0;
      req_bus.depth_mm               <= '0;
      req_bus.throttle_at_lower      <= 1'b0;
      req_bus.throttle_at_upper      <= 1'b0;
      rsp_bus.ready                  <= 1'b0;
      csr_psel                       <= 1'b0;
      csr_penable                    <= 1'b0;
      csr_pwrite                     <= 1'b0;
      csr_paddr                      <= '0;
      csr_pwdata                     <= '0;

      csr_shadow[REG_SURFACE_DEPTH] = reg_mask(REG_SURFACE_DEPTH) & 32'(SURFACE_DEPTH_RESET);
      csr_shadow[REG_SURFACE_HYST]  = 32'(SURFACE_HYST_RESET);
      csr_shadow[REG_STATION_LIMIT] = 32'(STATION_LIMIT_RESET);
      csr_shadow[REG_SURFACE_TRIG]  = 32'(SURFACE_TRIG_RESET);
      csr_shadow[REG_BOTTOM_TRIG]   = 32'(BOTTOM_TRIG_RESET);
      surf_flag     = 1'b0;
      bot_flag      = 1'b0;
      surf_cnt      = '0;
      bot_cnt       = '0;
      failures      = 0;
      ticks_sent    = 0;
      beats_checked = 0;
      surface_rises = 0;
      bottom_rises  = 0;
      settings_used = 0;
      steady_flow   = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_cases();
      test_extreme_settings();
      test_random_traffic();
      wait_drained();

      $display("Ran %0d ticks over %0d register settings, %0d result beats checked.",
               ticks_sent, settings_used, beats_checked);
      $display("Surfaced flag rose %0d times, bottomed flag rose %0d times.",
               surface_rises, bottom_rises);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
